[hdl/qrp_pkg.sv]
// ----------------------------------------------------------------------------
// qrp_pkg: shared types and helpers for the quaternion point rotator
// Item formats, widths of the datapath and the rounding helpers.
// ----------------------------------------------------------------------------
package qrp_pkg;

    // steps of the root chain and the divider chain
    localparam int SQ_STEPS  = 31;
    localparam int DIV_STEPS = 25;
    localparam int REM_W     = 61;   // m2 << 28
    localparam int ROOT_W    = 31;
    localparam int DREM_W    = 56;
    localparam int T_W       = 36;   // rotated-once vector, Q.16
    localparam int N_W       = 26;   // normalized conjugate, Q.24

    typedef struct packed {
        logic signed [15:0] quat_w;
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
        logic signed [31:0] vec_x;
        logic signed [31:0] vec_y;
        logic signed [31:0] vec_z;
    } t_in;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
    } t_out;

    // data that rides along the cell chains
    typedef struct packed {
        logic signed [T_W-1:0] tw;
        logic signed [T_W-1:0] tx;
        logic signed [T_W-1:0] ty;
        logic signed [T_W-1:0] tz;
        logic [3:0]            neg;   // sign of each conjugate lane (w,x,y,z)
        logic                  zero;  // zero quaternion
    } t_side;

    typedef struct packed {
        t_side               side;
        logic [3:0][15:0]    mag;
        logic [REM_W-1:0]    rem;
        logic [ROOT_W-1:0]   root;
    } t_sq;

    typedef struct packed {
        t_side                     side;
        logic [ROOT_W-1:0]         dsr;
        logic [3:0][DREM_W-1:0]    rem;
        logic [3:0][DIV_STEPS-1:0] quo;
    } t_dv;

    // shift right by 14, ties away from zero
    function automatic logic signed [T_W-1:0] rnd14(input logic signed [49:0] v);
        logic [49:0] m;
        logic [49:0] q;
        m = v[49] ? 50'(-v) : 50'(v);
        q = (m + 50'(1 << 13)) >> 14;
        return v[49] ? -(T_W'(q)) : T_W'(q);
    endfunction

    // shift right by 24, ties away from zero, then clamp to 32 bits
    function automatic logic signed [31:0] rnd24_sat(input logic signed [63:0] v);
        logic [63:0]        m;
        logic [63:0]        q;
        logic signed [40:0] s;
        m = v[63] ? 64'(-v) : 64'(v);
        q = (m + 64'(1 << 23)) >> 24;
        s = v[63] ? -(41'(q)) : 41'(q);
        if (s > 41'sd2147483647) begin
            return 32'h7fff_ffff;
        end else if (s < -41'sd2147483648) begin
            return 32'h8000_0000;
        end
        return s[31:0];
    endfunction

endpackage

[hdl/quaternion_rotate_point_core.sv]
// ----------------------------------------------------------------------------
// quaternion_rotate_point_core: rotate a Q16.16 point by a Q2.14 quaternion
// Computes q * (0,v) * conj(q)/|q| with rounding and saturation.
//
//   port       dir  meaning
//   start/i_item in  item strobe and quaternion + point
//   busy       out  always low, an item may enter every cycle
//   o_valid/o_result out  one-cycle result strobe and rotated point
//
// One item per clock. The pipeline holds product and sum stages, 31 root
// cells, a setup stage, 25 divider cells and two output stages. The root and
// divider chains set the depth. Reset clears only the valid bits. The receiver
// cannot stall: a result is shown for a single cycle.
// ----------------------------------------------------------------------------
module quaternion_rotate_point_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    input  qrp_pkg::t_in    i_item,
    output logic            busy,
    output logic            o_valid,
    output qrp_pkg::t_out   o_result
);

    localparam int SQN = qrp_pkg::SQ_STEPS;
    localparam int DVN = qrp_pkg::DIV_STEPS;

    // stage A: squares and vector products
    logic               r_a_vld;
    logic [3:0][31:0]   r_sq;
    logic signed [47:0] r_p [12];
    logic [3:0][15:0]   r_mag;
    logic [3:0]         r_neg;

    logic signed [15:0] qv [4];
    assign qv[0] = i_item.quat_w;
    assign qv[1] = i_item.quat_x;
    assign qv[2] = i_item.quat_y;
    assign qv[3] = i_item.quat_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else begin
            r_a_vld <= start;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 4; k++) begin
            r_sq[k]  <= 32'(qv[k] * qv[k]);
            r_mag[k] <= qv[k][15] ? 16'(-qv[k]) : 16'(qv[k]);
        end
        r_neg[0] <= qv[0][15];
        for (int k = 1; k < 4; k++) begin
            r_neg[k] <= !qv[k][15] && (qv[k] != 16'sd0);
        end
        r_p[0]  <= 48'(i_item.quat_x * i_item.vec_x);
        r_p[1]  <= 48'(i_item.quat_y * i_item.vec_y);
        r_p[2]  <= 48'(i_item.quat_z * i_item.vec_z);
        r_p[3]  <= 48'(i_item.quat_w * i_item.vec_x);
        r_p[4]  <= 48'(i_item.quat_y * i_item.vec_z);
        r_p[5]  <= 48'(i_item.quat_z * i_item.vec_y);
        r_p[6]  <= 48'(i_item.quat_w * i_item.vec_y);
        r_p[7]  <= 48'(i_item.quat_z * i_item.vec_x);
        r_p[8]  <= 48'(i_item.quat_x * i_item.vec_z);
        r_p[9]  <= 48'(i_item.quat_w * i_item.vec_z);
        r_p[10] <= 48'(i_item.quat_x * i_item.vec_y);
        r_p[11] <= 48'(i_item.quat_y * i_item.vec_x);
    end

    // stage B: magnitude squared and first product, into the root chain
    logic          sq_v [SQN+1];
    qrp_pkg::t_sq  sq_d [SQN+1];
    logic [32:0]   m2;
    qrp_pkg::t_sq  n_sq0;

    always_comb begin
        m2 = 33'(r_sq[0]) + 33'(r_sq[1]) + 33'(r_sq[2]) + 33'(r_sq[3]);
        n_sq0.mag       = r_mag;
        n_sq0.rem       = qrp_pkg::REM_W'(m2) << 28;
        n_sq0.root      = '0;
        n_sq0.side.neg  = r_neg;
        n_sq0.side.zero = (m2 == 33'd0);
        n_sq0.side.tw   = qrp_pkg::rnd14(-50'(r_p[0]) - 50'(r_p[1]) - 50'(r_p[2]));
        n_sq0.side.tx   = qrp_pkg::rnd14(50'(r_p[3]) + 50'(r_p[4]) - 50'(r_p[5]));
        n_sq0.side.ty   = qrp_pkg::rnd14(50'(r_p[6]) + 50'(r_p[7]) - 50'(r_p[8]));
        n_sq0.side.tz   = qrp_pkg::rnd14(50'(r_p[9]) + 50'(r_p[10]) - 50'(r_p[11]));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            sq_v[0] <= 1'b0;
        end else begin
            sq_v[0] <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        sq_d[0] <= n_sq0;
    end

    // root chain, most significant bit first
    for (genvar g = 0; g < SQN; g++) begin : g_sq
        qrp_sqrt_cell #(.BIT(SQN - 1 - g)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_vld   (sq_v[g]),
            .i_d     (sq_d[g]),
            .o_vld   (sq_v[g+1]),
            .o_d     (sq_d[g+1])
        );
    end

    // divider setup: numerator |c| << 38 plus half the root
    logic          dv_v [DVN+1];
    qrp_pkg::t_dv  dv_d [DVN+1];
    qrp_pkg::t_dv  n_dv0;

    always_comb begin
        n_dv0.side = sq_d[SQN].side;
        n_dv0.dsr  = sq_d[SQN].root;
        n_dv0.quo  = '0;
        for (int k = 0; k < 4; k++) begin
            n_dv0.rem[k] = (qrp_pkg::DREM_W'(sq_d[SQN].mag[k]) << 38)
                         + qrp_pkg::DREM_W'(sq_d[SQN].root >> 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            dv_v[0] <= 1'b0;
        end else begin
            dv_v[0] <= sq_v[SQN];
        end
    end

    always_ff @(posedge i_clk) begin
        dv_d[0] <= n_dv0;
    end

    for (genvar g = 0; g < DVN; g++) begin : g_dv
        qrp_div_cell #(.BIT(DVN - 1 - g)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_vld   (dv_v[g]),
            .i_d     (dv_d[g]),
            .o_vld   (dv_v[g+1]),
            .o_d     (dv_d[g+1])
        );
    end

    // normalized conjugate with signs; zero quaternion leaves it zero
    logic signed [qrp_pkg::N_W-1:0] nq [4];
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            if (dv_d[DVN].side.zero) begin
                nq[k] = '0;
            end else if (dv_d[DVN].side.neg[k]) begin
                nq[k] = -(qrp_pkg::N_W'(dv_d[DVN].quo[k]));
            end else begin
                nq[k] = qrp_pkg::N_W'(dv_d[DVN].quo[k]);
            end
        end
    end

    // stage C: second product terms
    logic               r_c_vld;
    logic signed [61:0] r_f [12];
    qrp_pkg::t_side     s;
    assign s = dv_d[DVN].side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else begin
            r_c_vld <= dv_v[DVN];
        end
    end

    always_ff @(posedge i_clk) begin
        r_f[0]  <= 62'(s.tx * nq[0]);
        r_f[1]  <= 62'(s.tw * nq[1]);
        r_f[2]  <= 62'(s.ty * nq[3]);
        r_f[3]  <= 62'(s.tz * nq[2]);
        r_f[4]  <= 62'(s.ty * nq[0]);
        r_f[5]  <= 62'(s.tw * nq[2]);
        r_f[6]  <= 62'(s.tz * nq[1]);
        r_f[7]  <= 62'(s.tx * nq[3]);
        r_f[8]  <= 62'(s.tz * nq[0]);
        r_f[9]  <= 62'(s.tw * nq[3]);
        r_f[10] <= 62'(s.tx * nq[2]);
        r_f[11] <= 62'(s.ty * nq[1]);
    end

    // stage D: sum, round, saturate
    logic          r_d_vld;
    qrp_pkg::t_out r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_vld <= 1'b0;
        end else begin
            r_d_vld <= r_c_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res.out_x <= qrp_pkg::rnd24_sat(64'(r_f[0]) + 64'(r_f[1])
                                        + 64'(r_f[2]) - 64'(r_f[3]));
        r_res.out_y <= qrp_pkg::rnd24_sat(64'(r_f[4]) + 64'(r_f[5])
                                        + 64'(r_f[6]) - 64'(r_f[7]));
        r_res.out_z <= qrp_pkg::rnd24_sat(64'(r_f[8]) + 64'(r_f[9])
                                        + 64'(r_f[10]) - 64'(r_f[11]));
    end

    assign busy     = 1'b0;
    assign o_valid  = r_d_vld;
    assign o_result = r_res;

endmodule

[hdl/qrp_sqrt_cell.sv]
// ----------------------------------------------------------------------------
// qrp_sqrt_cell: one bit of the integer square root
// Tries to set root bit BIT against the running remainder, then registers.
// ----------------------------------------------------------------------------
module qrp_sqrt_cell #(
    parameter int BIT = 0
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_vld,
    input  qrp_pkg::t_sq  i_d,
    output logic          o_vld,
    output qrp_pkg::t_sq  o_d
);

    localparam logic [62:0] SQ = 63'(1) << (2 * BIT);

    logic        r_vld;
    qrp_pkg::t_sq r_d;
    qrp_pkg::t_sq n_d;
    logic [62:0] trial;

    // (root + 2^BIT)^2 - root^2 = root*2^(BIT+1) + 2^(2*BIT)
    always_comb begin
        n_d   = i_d;
        trial = (63'(i_d.root) << (BIT + 1)) + SQ;
        if (63'(i_d.rem) >= trial) begin
            n_d.rem  = i_d.rem - trial[qrp_pkg::REM_W-1:0];
            n_d.root = i_d.root | (qrp_pkg::ROOT_W'(1) << BIT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_d <= n_d;
    end

    assign o_vld = r_vld;
    assign o_d   = r_d;

endmodule

[hdl/qrp_div_cell.sv]
// ----------------------------------------------------------------------------
// qrp_div_cell: one quotient bit for all four conjugate lanes
// Restoring division step against the divisor (the root) shifted to bit BIT.
// ----------------------------------------------------------------------------
module qrp_div_cell #(
    parameter int BIT = 0
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_vld,
    input  qrp_pkg::t_dv  i_d,
    output logic          o_vld,
    output qrp_pkg::t_dv  o_d
);

    logic         r_vld;
    qrp_pkg::t_dv r_d;
    qrp_pkg::t_dv n_d;
    logic [qrp_pkg::DREM_W-1:0] dsr;

    // compare and subtract per lane
    always_comb begin
        n_d = i_d;
        dsr = qrp_pkg::DREM_W'(i_d.dsr) << BIT;
        for (int k = 0; k < 4; k++) begin
            if (i_d.rem[k] >= dsr) begin
                n_d.rem[k]      = i_d.rem[k] - dsr;
                n_d.quo[k][BIT] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_d <= n_d;
    end

    assign o_vld = r_vld;
    assign o_d   = r_d;

endmodule
